// ----- hdl/savitzky_golay_fir_edge_hold_core_assert.svh -----
// assertion macros for the savitzky-golay edge-hold core
// used by the port checker; needs clk and arst_n in the including scope
`ifndef SAVITZKY_GOLAY_FIR_EDGE_HOLD_CORE_ASSERT_SVH
`define SAVITZKY_GOLAY_FIR_EDGE_HOLD_CORE_ASSERT_SVH

// clocked assertion, idle while reset is held
`define SGF_ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// same-cycle implication
`define SGF_ASSERT_IMPLY(label, ante, cons, msg) \
	`SGF_ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

// ----- hdl/sgf_pkg.sv -----
// shared types and constants for the savitzky-golay edge-hold core
// no dependencies
`timescale 1ns / 1ps

package sgf_pkg;

	localparam int SAMPLE_W = 16;
	localparam int COEFF_W  = 20;
	localparam int INDEX_W  = 5;
	localparam int HALF_W   = 4;
	localparam int OUT_W    = 24;
	localparam int FRAC_W   = 16;
	localparam int PROD_W   = SAMPLE_W + COEFF_W;

	// action codes
	localparam logic ACT_COEFF  = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	typedef struct packed {
		logic                       action;
		logic [INDEX_W-1:0]         coeff_index;
		logic signed [COEFF_W-1:0]  coeff_value;
		logic signed [SAMPLE_W-1:0] sample_in;
		logic                       last_sample;
	} in_word_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] value_out;
		logic                    too_short;
		logic                    last_out;
	} out_word_t;

	// per-cell control from the top level
	typedef struct packed {
		logic shift;   // sample moves one cell down the line
		logic rotate;  // coefficient ring advances one position
		logic load;    // this cell takes the incoming coefficient
		logic active;  // cell lies inside the current window
	} cell_ctrl_t;

endpackage

// ----- hdl/sgf_cell.sv -----
// one tap cell: sample register, coefficient register, registered product
// depends on sgf_pkg
`timescale 1ns / 1ps

module sgf_cell (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  sgf_pkg::cell_ctrl_t                   ctrl,
	input  logic signed [sgf_pkg::SAMPLE_W-1:0]   sample_prev,
	input  logic signed [sgf_pkg::COEFF_W-1:0]    coeff_prev,
	input  logic signed [sgf_pkg::COEFF_W-1:0]    coeff_new,
	output logic signed [sgf_pkg::SAMPLE_W-1:0]   sample_q,
	output logic signed [sgf_pkg::COEFF_W-1:0]    coeff_q,
	output logic signed [sgf_pkg::PROD_W-1:0]     prod_s1
);
	import sgf_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
		end else if (ctrl.shift) begin
			sample_q <= sample_prev;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			coeff_q <= coeff_new;
		end else if (ctrl.rotate) begin
			coeff_q <= coeff_prev;
		end
		// signed product at full width
		if (ctrl.active) begin
			prod_s1 <= sample_q * coeff_q;
		end else begin
			prod_s1 <= '0;
		end
	end

endmodule

// ----- hdl/sgf_sum_tree.sv -----
// registered pairwise adder tree, a register at every level
// no package dependency
`timescale 1ns / 1ps

module sgf_sum_tree #(
	parameter int N_LEAF = 25,
	parameter int IN_W   = 36,
	parameter int SUM_W  = 41
) (
	input  logic                    clk,
	input  logic signed [IN_W-1:0]  leaf [N_LEAF],
	output logic signed [SUM_W-1:0] sum
);
	localparam int LV = $clog2(N_LEAF);

	// nodes at a given depth
	function automatic int level_count(input int lvl);
		return (N_LEAF + (1 << lvl) - 1) >> lvl;
	endfunction

	logic signed [SUM_W-1:0] node_q [LV][N_LEAF];

	always_ff @(posedge clk) begin
		for (int k = 0; k < N_LEAF; k++) begin
			if (2 * k + 1 < N_LEAF) begin
				node_q[0][k] <= SUM_W'(leaf[2*k]) + SUM_W'(leaf[2*k+1]);
			end else if (2 * k < N_LEAF) begin
				node_q[0][k] <= SUM_W'(leaf[2*k]);
			end else begin
				node_q[0][k] <= '0;
			end
		end
		for (int l = 1; l < LV; l++) begin
			for (int k = 0; k < N_LEAF; k++) begin
				if (2 * k + 1 < level_count(l)) begin
					node_q[l][k] <= node_q[l-1][2*k] + node_q[l-1][2*k+1];
				end else if (2 * k < level_count(l)) begin
					node_q[l][k] <= node_q[l-1][2*k];
				end else begin
					node_q[l][k] <= '0;
				end
			end
		end
	end

	assign sum = node_q[LV-1][0];

endmodule

// ----- hdl/savitzky_golay_fir_edge_hold_core.sv -----
// savitzky-golay fir with edge hold: top level
// depends on sgf_pkg, sgf_cell, sgf_sum_tree
`timescale 1ns / 1ps

// channel  | handshake                | word / data
// ---------+--------------------------+-------------------------------
// input    | in_valid / in_ready      | in_word  (coefficient or sample)
// output   | out_valid / out_ready    | out_word (filtered result)
// config   | cfg_we (no wait)         | cfg_wdata (half window M)
//
// one input word per cycle while in_ready is high, coefficient loads and samples alike;
// one result per cycle while out_ready is high; an accepted sample reaches out_valid
// via sample and product registers, adder tree levels, result queue, output register
// edge fills repeat one result M+1 or 2M+1 times from the output register, one per
// cycle while out_ready is high; in_ready drops once 16 result entries are pending
// in the pipe, queue and output register; after a half window write, in_ready is low
// while the coefficient ring turns to the new alignment; no clearing pass after reset

module savitzky_golay_fir_edge_hold_core #(
	parameter int MAX_HALF_WINDOW = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  sgf_pkg::in_word_t             in_word,
	output logic                          out_valid,
	input  logic                          out_ready,
	output sgf_pkg::out_word_t            out_word,
	input  logic                          cfg_we,
	input  logic [sgf_pkg::HALF_W-1:0]    cfg_wdata
);
	import sgf_pkg::*;

	// window geometry
	localparam int N     = 2 * MAX_HALF_WINDOW + 1;   // taps in the cell row
	localparam int MW    = $clog2(MAX_HALF_WINDOW + 1);
	localparam int AW    = $clog2(N);                 // ring alignment
	localparam int SW    = $clog2(N + 1);             // sample count, repeat count
	localparam int TW    = ((AW > INDEX_W) ? AW : INDEX_W) + 1;
	localparam int LV    = $clog2(N);                 // adder tree depth
	localparam int ACC_W = PROD_W + LV;
	localparam int RW    = ACC_W + 1;
	localparam int MP    = LV + 2;                    // side-band stages to the queue
	localparam int FD    = 16;                        // result queue depth
	localparam int FAW   = $clog2(FD);
	localparam int CW    = $clog2(FD + 1);
	localparam int RST_HALF = (MAX_HALF_WINDOW < 2) ? MAX_HALF_WINDOW : 2;

	localparam logic signed [RW-1:0] SAT_HI = RW'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
	localparam logic signed [RW-1:0] SAT_LO = ~SAT_HI;

	typedef struct packed {
		logic          emit;
		logic          too_short;
		logic [SW-1:0] reps;
	} meta_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] value;
		logic                    too_short;
		logic [SW-1:0]           reps;
	} res_ent_t;

	// config and alignment state
	logic [HALF_W-1:0] half_window_q;
	logic [MW-1:0]     m_eff;
	logic [AW-1:0]     align_q;
	logic [AW-1:0]     align_tgt;
	logic              aligned;

	// front control
	logic [SW-1:0] seen_q;
	logic [SW-1:0] seen_inc;
	logic [SW-1:0] taps;
	logic [SW-1:0] reps_full;
	logic          win_full;
	logic          win_first;
	logic          smp_acc;
	logic          coef_acc;
	logic          idx_ok;
	logic [TW-1:0] tgt_sum;
	logic [TW-1:0] tgt_cell;
	meta_t         meta_new;
	meta_t         meta_q [MP];

	// cell row
	cell_ctrl_t              cctrl  [N];
	logic signed [SAMPLE_W-1:0] samp [N];
	logic signed [COEFF_W-1:0]  coef [N];
	logic signed [PROD_W-1:0]   prod [N];
	logic signed [ACC_W-1:0]    acc;

	// rounding
	logic signed [RW-1:0]    rnd;
	logic signed [OUT_W-1:0] sat_val;
	res_ent_t                push_ent;

	// result queue and output register
	res_ent_t                fifo_q [FD];
	logic [FAW:0]            wr_ptr_q;
	logic [FAW:0]            rd_ptr_q;
	logic                    fifo_empty;
	logic                    pop;
	logic                    done;
	logic [CW-1:0]           cnt_q;
	logic                    out_valid_q;
	logic signed [OUT_W-1:0] out_val_q;
	logic                    out_short_q;
	logic [SW-1:0]           rem_q;

	// ---------------------------------------------------------------
	// half window register, clamped into 1..MAX_HALF_WINDOW
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_window_q <= HALF_W'(2);
		end else if (cfg_we) begin
			half_window_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (half_window_q == '0) begin
			m_eff = MW'(1);
		end else if (int'(half_window_q) > MAX_HALF_WINDOW) begin
			m_eff = MW'(MAX_HALF_WINDOW);
		end else begin
			m_eff = MW'(half_window_q);
		end
	end

	// cell i holds coefficient h[(align - i) mod N]; the window needs align = 2M,
	// so the ring turns one place a cycle until it gets there
	assign align_tgt = AW'({m_eff, 1'b0});
	assign aligned   = (align_q == align_tgt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			align_q <= AW'(2 * RST_HALF);
		end else if (!aligned) begin
			align_q <= (align_q == AW'(N - 1)) ? '0 : align_q + AW'(1);
		end
	end

	// ---------------------------------------------------------------
	// input side: accept, window fill tracking, repeat count
	// ---------------------------------------------------------------
	assign in_ready = aligned && (cnt_q < CW'(FD));
	assign smp_acc  = in_valid && in_ready && (in_word.action == ACT_SAMPLE);
	assign coef_acc = in_valid && in_ready && (in_word.action == ACT_COEFF);

	always_comb begin
		seen_inc  = (seen_q < SW'(N)) ? seen_q + SW'(1) : seen_q;
		taps      = SW'({m_eff, 1'b1});
		win_full  = (seen_inc >= taps);
		win_first = (seen_q < taps);
		// leading fill adds M copies, trailing fill adds M more
		reps_full = SW'(1) + (win_first ? SW'(m_eff) : '0)
		          + (in_word.last_sample ? SW'(m_eff) : '0);
		meta_new.emit      = smp_acc && (win_full || in_word.last_sample);
		meta_new.too_short = !win_full;
		meta_new.reps      = win_full ? reps_full : SW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (smp_acc) begin
			// a last-marked sample closes the run whether it was long enough or not
			seen_q <= in_word.last_sample ? '0 : seen_inc;
		end
	end

	// coefficient write goes to the cell that currently maps to that tap
	always_comb begin
		idx_ok   = (int'(in_word.coeff_index) < N);
		tgt_sum  = TW'(align_q) + TW'(N) - TW'(in_word.coeff_index);
		tgt_cell = (tgt_sum >= TW'(N)) ? tgt_sum - TW'(N) : tgt_sum;
	end

	// ---------------------------------------------------------------
	// cell row: samples shift newest-first, coefficients sit on a ring
	// ---------------------------------------------------------------
	for (genvar i = 0; i < N; i++) begin : g_cell
		localparam int PREV = (i == 0) ? N - 1 : i - 1;

		always_comb begin
			cctrl[i].shift  = smp_acc;
			cctrl[i].rotate = !aligned;
			cctrl[i].load   = coef_acc && idx_ok && (tgt_cell == TW'(i));
			// taps past 2M carry no weight
			cctrl[i].active = (AW'(i) <= align_q);
		end

		if (i == 0) begin : g_head
			sgf_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctrl        (cctrl[i]),
				.sample_prev (in_word.sample_in),
				.coeff_prev  (coef[PREV]),
				.coeff_new   (in_word.coeff_value),
				.sample_q    (samp[i]),
				.coeff_q     (coef[i]),
				.prod_s1     (prod[i])
			);
		end else begin : g_body
			sgf_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctrl        (cctrl[i]),
				.sample_prev (samp[i-1]),
				.coeff_prev  (coef[PREV]),
				.coeff_new   (in_word.coeff_value),
				.sample_q    (samp[i]),
				.coeff_q     (coef[i]),
				.prod_s1     (prod[i])
			);
		end
	end

	sgf_sum_tree #(
		.N_LEAF (N),
		.IN_W   (PROD_W),
		.SUM_W  (ACC_W)
	) u_tree (
		.clk  (clk),
		.leaf (prod),
		.sum  (acc)
	);

	// side band follows the sample through products and tree levels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MP; k++) begin
				meta_q[k] <= '0;
			end
		end else begin
			meta_q[0] <= meta_new;
			for (int k = 1; k < MP; k++) begin
				meta_q[k] <= meta_q[k-1];
			end
		end
	end

	// ---------------------------------------------------------------
	// round half up from q16, saturate to the output width
	// ---------------------------------------------------------------
	always_comb begin
		rnd = RW'(acc >>> FRAC_W) + RW'(acc[FRAC_W-1]);
		if (rnd > SAT_HI) begin
			sat_val = SAT_HI[OUT_W-1:0];
		end else if (rnd < SAT_LO) begin
			sat_val = SAT_LO[OUT_W-1:0];
		end else begin
			sat_val = rnd[OUT_W-1:0];
		end
		push_ent.value     = meta_q[MP-1].too_short ? '0 : sat_val;
		push_ent.too_short = meta_q[MP-1].too_short;
		push_ent.reps      = meta_q[MP-1].reps;
	end

	// ---------------------------------------------------------------
	// result queue; entries are counted from acceptance so it never overflows
	// ---------------------------------------------------------------
	assign fifo_empty = (wr_ptr_q == rd_ptr_q);
	assign done       = out_valid_q && out_ready && (rem_q == SW'(1));
	assign pop        = !fifo_empty && (!out_valid_q || done);

	always_ff @(posedge clk) begin
		if (meta_q[MP-1].emit) begin
			fifo_q[wr_ptr_q[FAW-1:0]] <= push_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (meta_q[MP-1].emit) begin
				wr_ptr_q <= wr_ptr_q + (FAW+1)'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + (FAW+1)'(1);
			end
			case ({meta_new.emit, done})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// output register: replays one entry rem_q times for the edge fills
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rem_q       <= '0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
			rem_q       <= fifo_q[rd_ptr_q[FAW-1:0]].reps;
		end else if (out_valid_q && out_ready) begin
			if (rem_q == SW'(1)) begin
				out_valid_q <= 1'b0;
			end else begin
				rem_q <= rem_q - SW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_val_q   <= fifo_q[rd_ptr_q[FAW-1:0]].value;
			out_short_q <= fifo_q[rd_ptr_q[FAW-1:0]].too_short;
		end
	end

	assign out_valid          = out_valid_q;
	assign out_word.value_out = out_val_q;
	assign out_word.too_short = out_short_q;
	assign out_word.last_out  = (rem_q == SW'(1));

endmodule

// ----- hdl/sgf_port_checker.sv -----
// port-level checks for the savitzky-golay edge-hold core, bound to the top
// depends on sgf_pkg and savitzky_golay_fir_edge_hold_core_assert.svh
`timescale 1ns / 1ps
`include "savitzky_golay_fir_edge_hold_core_assert.svh"

module sgf_port_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input sgf_pkg::out_word_t         out_word
);

	// handshake outputs always known out of reset
	`SGF_ASSERT_CLK(hs_known_a, !$isunknown(in_ready) && !$isunknown(out_valid), "handshake output unknown")

	// stalled result word stays put
	`SGF_ASSERT_CLK(out_hold_a, out_valid && !out_ready |=> out_valid && $stable(out_word), "result word changed while stalled")

	// a short-run error is a single zero word that closes the run
	`SGF_ASSERT_IMPLY(short_form_a, out_valid && out_word.too_short, out_word.last_out && (out_word.value_out == '0), "short-run result malformed")

	// fill copies follow back to back with the same value
	`SGF_ASSERT_CLK(fill_run_a, out_valid && out_ready && !out_word.last_out |=> out_valid && !out_word.too_short && (out_word.value_out == $past(out_word.value_out)), "edge fill broken")

endmodule

bind savitzky_golay_fir_edge_hold_core sgf_port_checker u_port_checker (.*);
